// ----- rtl/i2c_master_bit_engine_top_assert.svh -----
// Assertion macros for the I2C master bit engine checker.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define MBE_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("i2c bit engine check failed");

// Next-cycle implication, masked during reset.
`define MBE_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("i2c bit engine check failed");

// Next-cycle implication that also covers the reset cycle.
`define MBE_ASSERT_RST(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("i2c bit engine reset check failed");

`endif

// ----- rtl/i2c_mbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package i2c_mbe_pkg;

  localparam logic [2:0]  OP_START   = 3'd0;
  localparam logic [2:0]  OP_RESTART = 3'd1;
  localparam logic [2:0]  OP_STOP    = 3'd2;
  localparam logic [2:0]  OP_WRITE   = 3'd3;
  localparam logic [2:0]  OP_READ    = 3'd4;

  localparam logic [15:0] PHASE_TICKS_RESET   = 16'd2000;
  localparam int          QUEUE_DEPTH_DEFAULT = 2;
  localparam logic [7:0]  MSB_MASK            = 8'h80;
  localparam logic [3:0]  ACK_SLOT            = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_ack;
    logic [8:0] bus_sda;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic [7:0] read_data;
    logic       ack_received;
    logic       last;
  } out_word_t;

  typedef enum logic [3:0] {
    KIND_START = 4'b0001,
    KIND_STOP  = 4'b0010,
    KIND_WRITE = 4'b0100,
    KIND_READ  = 4'b1000
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       send_ack;
    logic [8:0] bus_sda;
  } cmd_t;

endpackage

// ----- rtl/i2c_mbe_front.sv -----
// Front end: accepts command words and decodes them into queue entries.
module i2c_mbe_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2c_mbe_pkg::in_word_t in_word,
  output logic                 push,
  output i2c_mbe_pkg::cmd_t    push_cmd,
  input  logic                 queue_full
);
  import i2c_mbe_pkg::*;

  logic known;

  // Undefined opcodes are accepted and dropped.
  always_comb begin
    known         = 1'b1;
    push_cmd.kind = KIND_START;
    case (in_word.operation) inside
      OP_START, OP_RESTART: push_cmd.kind = KIND_START;
      OP_STOP:              push_cmd.kind = KIND_STOP;
      OP_WRITE:             push_cmd.kind = KIND_WRITE;
      OP_READ:              push_cmd.kind = KIND_READ;
      default:              known = 1'b0;
    endcase
    push_cmd.data     = in_word.write_data;
    push_cmd.send_ack = in_word.send_ack;
    push_cmd.bus_sda  = in_word.bus_sda;
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready && known;

endmodule

// ----- rtl/i2c_mbe_queue.sv -----
// Small command queue between the front end and the phase sequencer.
module i2c_mbe_queue #(
  parameter int DEPTH = i2c_mbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2c_mbe_pkg::cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output i2c_mbe_pkg::cmd_t head_cmd
);
  import i2c_mbe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/i2c_mbe_back.sv -----
// Back end: expands the head command into timed bus phases.
module i2c_mbe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           phase_ticks,
  input  logic                  head_valid,
  input  i2c_mbe_pkg::cmd_t     head_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2c_mbe_pkg::out_word_t out_word
);
  import i2c_mbe_pkg::*;

  logic [1:0]  sub;
  logic [1:0]  sub_next;
  logic [3:0]  bit_cnt;
  logic [3:0]  bit_cnt_next;
  logic [15:0] timer;
  logic        scl_level;
  logic        load;
  logic        in_ack;
  logic        slot_end;
  logic        tx_bit;
  out_word_t   phase;

  assign in_ack = (bit_cnt == ACK_SLOT);
  assign tx_bit = |(head_cmd.data & (MSB_MASK >> bit_cnt[2:0]));

  // Phase table for the current slot.
  always_comb begin
    phase    = '0;
    slot_end = 1'b0;
    case (head_cmd.kind)
      KIND_START: begin
        phase.scl         = (sub == 2'd0) ? scl_level : (sub != 2'd3);
        phase.sda_release = (sub < 2'd2);
        phase.last        = (sub == 2'd3);
      end
      KIND_STOP: begin
        phase.scl         = (sub == 2'd0) ? scl_level : 1'b1;
        phase.sda_release = (sub == 2'd2);
        phase.last        = (sub == 2'd2);
      end
      KIND_WRITE: begin
        slot_end = (sub == 2'd2);
        if (in_ack) begin
          phase.scl          = (sub == 2'd1);
          phase.sda_release  = 1'b1;
          phase.last         = (sub == 2'd2);
          phase.ack_received = phase.last && !head_cmd.bus_sda[0];
        end else begin
          phase.scl         = (sub == 2'd0) ? scl_level : (sub == 2'd1);
          phase.sda_release = tx_bit;
        end
      end
      KIND_READ: begin
        if (in_ack) begin
          slot_end          = (sub == 2'd2);
          phase.scl         = (sub == 2'd1);
          phase.sda_release = !head_cmd.send_ack;
          phase.last        = (sub == 2'd2);
          phase.read_data   = phase.last ? head_cmd.bus_sda[8:1] : 8'd0;
        end else begin
          slot_end          = (sub == 2'd1);
          phase.scl         = (sub == 2'd0);
          phase.sda_release = 1'b1;
        end
      end
      default: phase = '0;
    endcase
  end

  assign load = head_valid && (timer == '0) && (!out_valid || out_ready);
  assign pop  = load && phase.last;

  always_comb begin
    sub_next     = sub;
    bit_cnt_next = bit_cnt;
    if (load) begin
      if (phase.last) begin
        sub_next     = '0;
        bit_cnt_next = '0;
      end else if (slot_end) begin
        sub_next     = '0;
        bit_cnt_next = bit_cnt + 4'd1;
      end else begin
        sub_next = sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= '0;
      bit_cnt   <= '0;
      timer     <= '0;
      scl_level <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      sub     <= sub_next;
      bit_cnt <= bit_cnt_next;
      if (load) begin
        timer     <= (phase_ticks == '0) ? '0 : phase_ticks - 16'd1;
        scl_level <= phase.scl;
        out_valid <= 1'b1;
      end else begin
        if (timer != '0) begin
          timer <= timer - 16'd1;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= phase;
    end
  end

endmodule

// ----- rtl/i2c_master_bit_engine_top.sv -----
// I2C master bit engine: an accepted command is written to the queue; with the back end idle, the
//   back end then registers its first phase word. The phase timer, loaded from phase_ticks,
//   paces the words and out_ready can hold them; start 4 phases, stop 3, write 27, read 19.
// Up to QUEUE_DEPTH decoded commands are held; the head one is the command in progress.
// Reset (rst, synchronous, high): queue empty, no output word, timer clear,
//   tracked SCL level high, phase_ticks back to 2000.
module i2c_master_bit_engine_top #(
  parameter int QUEUE_DEPTH = i2c_mbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2c_mbe_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2c_mbe_pkg::out_word_t out_word,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata
);
  import i2c_mbe_pkg::*;

  logic        push;
  cmd_t        push_cmd;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  cmd_t        head_cmd;
  logic [15:0] phase_ticks;

  // Phase length register; user must write it only while the engine is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  // Decode: opcodes 5..7 are swallowed without producing a word.
  i2c_mbe_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Decouples intake from the slow bus sequencing.
  i2c_mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Sequencer: walks the head command phase by phase into a registered output.
  i2c_mbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule

// ----- rtl/i2c_mbe_checker.sv -----
// Port-level checker for the I2C master bit engine, bound to the top level.
`include "i2c_master_bit_engine_top_assert.svh"

module i2c_mbe_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input i2c_mbe_pkg::out_word_t out_word
);
  import i2c_mbe_pkg::*;

  `MBE_ASSERT_RST(a_rst_no_word, clk, rst, !out_valid)
  `MBE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(out_word))
  `MBE_ASSERT_IMP(a_mid_phase_clean, clk, rst, out_valid && !out_word.last,
                  out_word.read_data == 8'd0 && !out_word.ack_received)
  `MBE_ASSERT_IMP(a_ack_not_read, clk, rst, out_valid && out_word.ack_received,
                  out_word.read_data == 8'd0 && out_word.sda_release)

endmodule

bind i2c_master_bit_engine_top i2c_mbe_checker u_chk (.*);

// ----- bench/i2c_mbe_phase_checker.sv -----
// Checker for the I2C master bit engine: predicts the bus phase words of each command and compares.
module i2c_mbe_phase_checker
  import i2c_mbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  output int        words_pending,
  output int        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  out_word_t   phases_due[$];
  logic        scl_level;
  logic        sda_level;
  logic [15:0] phase_ticks_shadow;
  int          mismatch_count = 0;
  int          word_index = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH (phase_ticks %0d): %s", $realtime, phase_ticks_shadow, what);
    end
    mismatch_count++;
  endtask

  // One bus phase; the final phase of a command carries read byte / ack flag.
  task automatic push_phase(input logic scl, input logic sda, input logic fin,
                            input logic [7:0] rdata, input logic ackr);
    out_word_t w;
    scl_level = scl;
    sda_level = sda;
    w.scl = scl;
    w.sda_release = sda;
    w.read_data = fin ? rdata : 8'h00;
    w.ack_received = fin ? ackr : 1'b0;
    w.last = fin;
    phases_due.push_back(w);
  endtask

  task automatic expand_command(input in_word_t cmd);
    logic nak;
    int   i;
    nak = ~cmd.send_ack;
    case (cmd.operation)
      OP_START, OP_RESTART: begin
        push_phase(scl_level, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
      end
      OP_STOP: begin
        push_phase(scl_level, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
      end
      OP_WRITE: begin
        for (i = 7; i >= 0; i--) begin
          push_phase(scl_level, cmd.write_data[i], 1'b0, 8'h00, 1'b0);
          push_phase(1'b1, cmd.write_data[i], 1'b0, 8'h00, 1'b0);
          push_phase(1'b0, cmd.write_data[i], 1'b0, 8'h00, 1'b0);
        end
        // ack slot: slave pulls SDA low to acknowledge
        push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 8'h00, ~cmd.bus_sda[0]);
      end
      OP_READ: begin
        for (i = 0; i < 8; i++) begin
          push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
          push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        end
        push_phase(1'b0, nak, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, nak, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, nak, 1'b1, cmd.bus_sda[8:1], 1'b0);
      end
      default: ;  // unknown operation: no phases, state untouched
    endcase
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t exp_w;
    string     diffs;
    diffs = "";
    if (phases_due.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected (got %h)",
                                word_index, got));
    end else begin
      exp_w = phases_due.pop_front();
      if (got.scl !== exp_w.scl) diffs = {diffs, " scl"};
      if (got.sda_release !== exp_w.sda_release) diffs = {diffs, " sda_release"};
      if (got.read_data !== exp_w.read_data) diffs = {diffs, " read_data"};
      if (got.ack_received !== exp_w.ack_received) diffs = {diffs, " ack_received"};
      if (got.last !== exp_w.last) diffs = {diffs, " last"};
      if (diffs != "") begin
        report_mismatch($sformatf("word %0d:%s differ, got %h expected %h",
                                  word_index, diffs, got, exp_w));
      end
    end
    word_index++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phases_due.delete();
      scl_level = 1'b1;
      sda_level = 1'b1;
      phase_ticks_shadow = PHASE_TICKS_RESET;
      word_index = 0;
    end else begin
      if (cfg_we) phase_ticks_shadow = cfg_wdata;
      if (in_valid && in_ready) expand_command(in_word);
      if (out_valid && out_ready) check_word(out_word);
    end
    words_pending <= phases_due.size();
    fail_count <= mismatch_count;
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the I2C master bit engine bench: clock, reset, command stimulus, pacing and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2c_mbe_pkg::*;

  // The longest quiet stretch is one phase at the largest phase_ticks plus
  // the settle after it.
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES    = 500;   // receiver hold-off that backs the engine up
  localparam int SETTLE_CYCLES  = 20;    // slack past the accept latency
  localparam int IDLE_PCT       = 37;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int   words_pending;
  int   fail_count;
  int   stall_cycles;
  int   cmds_sent;     // commands that the engine acts on (ops 0..4)
  int   cur_ticks;
  logic tx_steady;     // sender offers back to back
  logic rx_steady;     // receiver always ready
  logic rx_hold_req;   // asks the receiver for one long hold-off

  i2c_master_bit_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2c_mbe_phase_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .words_pending (words_pending),
    .fail_count    (fail_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input known from time zero; reset held once at the start.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold_req = 1'b0;
    cmds_sent = 0;
    cur_ticks = PHASE_TICKS_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d phase words still due",
               $realtime, stall_cycles, words_pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure, a steady mode, and one long hold-off
  // that it counts out itself while the sender keeps pushing commands.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_steady || $urandom_range(99) >= IDLE_PCT) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
      end
    end
  end

  function automatic in_word_t cmd(input logic [2:0] op, input logic [7:0] data,
                                   input logic ack, input logic [8:0] bus);
    in_word_t w;
    w.operation = op;
    w.write_data = data;
    w.send_ack = ack;
    w.bus_sda = bus;
    return w;
  endfunction

  // Random payload around a chosen operation; every field bit gets exercised.
  function automatic in_word_t rand_cmd(input logic [2:0] op);
    return cmd(op, 8'($urandom), 1'($urandom), 9'($urandom));
  endfunction

  // Called at a falling edge. Returns at the falling edge after the accept,
  // with valid still up so a following word can go out back to back.
  task automatic send_word(input in_word_t w);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    if (w.operation <= OP_READ) cmds_sent++;
    @(negedge clk);
  endtask

  // Stop offering, wait until every predicted phase word has been taken, then
  // give the engine time to finish any command that makes no words.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES + cur_ticks) @(negedge clk);
  endtask

  // Only called with the engine idle.
  task automatic set_phase_ticks(input logic [15:0] ticks);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    cur_ticks = ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed transfers (start, a few bytes, maybe a repeated start
  // and a read, stop), sometimes left without a stop, plus raw noise commands.
  task automatic random_traffic(input int count);
    int goal;
    int n;
    goal = cmds_sent + count;
    while (cmds_sent < goal) begin
      if ($urandom_range(99) < 80) begin
        send_word(rand_cmd($urandom_range(1) ? OP_START : OP_RESTART));
        n = $urandom_range(1, 4);
        repeat (n) send_word(rand_cmd($urandom_range(1) ? OP_WRITE : OP_READ));
        if ($urandom_range(3) == 0) begin
          send_word(rand_cmd(OP_RESTART));
          send_word(rand_cmd(OP_READ));
        end
        if ($urandom_range(7) != 0) send_word(rand_cmd(OP_STOP));
      end else begin
        send_word(rand_cmd(3'($urandom_range(7))));
      end
    end
  endtask

  initial begin : stimulus
    do @(negedge clk); while (rst);

    // Reset value of phase_ticks (2000): a start straight out of reset, with
    // SCL still high from reset, and a stop.
    send_word(cmd(OP_START, 8'h00, 1'b0, 9'h000));
    send_word(cmd(OP_STOP, 8'hff, 1'b1, 9'h1ff));
    wait_drain();

    // Minimum phase length for the directed list.
    set_phase_ticks(16'd1);
    // write right after a stop: first phase keeps SCL high; ack low, data bits ignored
    send_word(cmd(OP_WRITE, 8'h5a, 1'b0, 9'h1fe));
    send_word(cmd(OP_WRITE, 8'hff, 1'b1, 9'h001));  // NACK
    send_word(cmd(OP_WRITE, 8'h00, 1'b0, 9'h000));
    // reads: ack slot bit ignored, both ACK and NACK driven
    send_word(cmd(OP_READ, 8'hff, 1'b1, 9'h1ff));
    send_word(cmd(OP_READ, 8'h00, 1'b0, 9'h000));
    send_word(cmd(OP_RESTART, 8'ha5, 1'b1, 9'h155));
    send_word(cmd(OP_READ, 8'h00, 1'b1, 9'h0aa));
    send_word(cmd(OP_WRITE, 8'h80, 1'b1, 9'h155));
    send_word(cmd(OP_STOP, 8'h00, 1'b0, 9'h000));
    send_word(cmd(OP_STOP, 8'h00, 1'b0, 9'h000));   // stop with SCL already high
    send_word(cmd(OP_START, 8'h00, 1'b0, 9'h000));  // start with SCL high
    // unknown operations: no phase words, tracked levels untouched
    send_word(cmd(3'd5, 8'hff, 1'b1, 9'h1ff));
    send_word(cmd(3'd6, 8'h00, 1'b0, 9'h000));
    send_word(cmd(3'd7, 8'h3c, 1'b1, 9'h0f0));
    send_word(cmd(OP_READ, 8'h00, 1'b0, 9'h155));
    send_word(cmd(OP_WRITE, 8'h01, 1'b0, 9'h0fe));
    send_word(cmd(OP_STOP, 8'h00, 1'b1, 9'h000));
    send_word(cmd(OP_READ, 8'h00, 1'b1, 9'h02a));   // read straight after a stop
    send_word(cmd(OP_STOP, 8'h00, 1'b1, 9'h000));

    // Random traffic with idling on both sides.
    random_traffic(30);

    // Receiver holds off while the sender streams: the queue fills and
    // in_ready drops. Then the sender waits for every word to come back.
    tx_steady = 1'b1;
    rx_hold_req = 1'b1;
    random_traffic(6);
    tx_steady = 1'b0;
    wait_drain();

    // Longest phase: a lone stop keeps the run short.
    set_phase_ticks(16'hffff);
    send_word(cmd(OP_STOP, 8'h00, 1'b0, 9'h000));
    wait_drain();

    // Short phases: a stretch with no idling anywhere, then random idling again.
    set_phase_ticks(16'd3);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_traffic(15);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    random_traffic(20);
    wait_drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- i2c_master_bit_engine_top.f -----
+incdir+rtl
rtl/i2c_mbe_pkg.sv
rtl/i2c_mbe_front.sv
rtl/i2c_mbe_queue.sv
rtl/i2c_mbe_back.sv
rtl/i2c_master_bit_engine_top.sv
rtl/i2c_mbe_checker.sv
bench/i2c_mbe_phase_checker.sv
bench/tb_top.sv
